### hw/rtl/mts_pkg.sv
// Package for the minimum-tracking stack: action codes, widths and shared types.
// Used by the channel interfaces, the stack cell and the top level.
// No dependencies.
package mts_pkg;

	localparam int DATA_W        = 32;
	localparam int ACTION_W      = 2;
	localparam int DEPTH_DEFAULT = 64;

	// Action codes; code 3 is unused and acts as a query.
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_POP  = 2'd2;

	// Top and minimum read as all ones when the stack is empty.
	localparam logic signed [DATA_W-1:0] EMPTY_READ = '1;

	typedef struct packed {
		logic signed [DATA_W-1:0] min_value;
		logic signed [DATA_W-1:0] value;
	} entry_t;

	// Shift command broadcast to every cell of the chain.
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctrl_t;

endpackage

### hw/rtl/mts_req_if.sv
// Request channel of the minimum-tracking stack: valid, ready, action and value.
// Depends on mts_pkg.
interface mts_req_if;
	import mts_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ACTION_W-1:0]      action;
	logic signed [DATA_W-1:0] value;

	modport source(output valid, output action, output value, input ready);
	modport sink(input valid, input action, input value, output ready);

endinterface

### hw/rtl/mts_rsp_if.sv
// Response channel of the minimum-tracking stack: top, minimum and status flags.
// Depends on mts_pkg.
interface mts_rsp_if;
	import mts_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] top_value;
	logic signed [DATA_W-1:0] min_value;
	logic                     is_empty;
	logic                     overflow;

	modport source(output valid, output top_value, output min_value, output is_empty,
		output overflow, input ready);
	modport sink(input valid, input top_value, input min_value, input is_empty,
		input overflow, output ready);

endinterface

### hw/rtl/mts_cell.sv
// One cell of the stack chain: holds a single entry and moves it one place
// down on a push or up on a pop. Depends on mts_pkg.
module mts_cell (
	input  logic                 clk,
	input  mts_pkg::shift_ctrl_t ctrl,
	input  mts_pkg::entry_t      from_above,
	input  mts_pkg::entry_t      from_below,
	output mts_pkg::entry_t      entry
);
	import mts_pkg::*;

	entry_t entry_q;

	// Entry contents are only meaningful below the fill count, so no reset.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entry_q <= from_above;
		end else if (ctrl.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

### hw/rtl/min_tracking_stack_top.sv
// Top level of the minimum-tracking stack: request and response channels,
// fill count, the chain of cells and the registered response.
// Depends on mts_pkg, mts_req_if, mts_rsp_if and mts_cell.

// The stack holds up to DEPTH signed 32-bit values in a chain of cells with
// the top entry in the first cell; each entry carries the running minimum
// at its depth. A push shifts the whole chain down one place and a pop
// shifts it up one place in the same cycle, and a new request can be taken
// every cycle unless a waiting response is stalled. Each request gives one
// response from an output register in the cycle after acceptance; a new
// request is taken while the previous response is still waiting only if
// that response is taken in the same cycle. An empty stack reads -1 for
// top and minimum, a pop on it is ignored, and a push onto a full stack is
// dropped with overflow set.
module min_tracking_stack_top #(
	parameter int DEPTH = mts_pkg::DEPTH_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);
	import mts_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]         count_q;
	entry_t                   cells [DEPTH];
	entry_t                   new_entry;
	shift_ctrl_t              ctrl;
	logic                     accept;
	logic                     is_push;
	logic                     is_pop;
	logic                     stack_empty;
	logic                     stack_full;

	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] rsp_top_q;
	logic signed [DATA_W-1:0] rsp_min_q;
	logic                     rsp_empty_q;
	logic                     rsp_ovf_q;

	logic signed [DATA_W-1:0] nxt_top;
	logic signed [DATA_W-1:0] nxt_min;
	logic                     nxt_empty;

	assign req.ready   = !rsp_valid_q || rsp.ready;
	assign accept      = req.valid && req.ready;
	assign is_push     = req.action == ACT_PUSH;
	assign is_pop      = req.action == ACT_POP;
	assign stack_empty = count_q == '0;
	assign stack_full  = count_q == CNT_W'(DEPTH);

	assign ctrl.push = accept && is_push && !stack_full;
	assign ctrl.pop  = accept && is_pop && !stack_empty;

	always_comb begin
		new_entry.value = req.value;
		if (stack_empty || req.value < cells[0].min_value) begin
			new_entry.min_value = req.value;
		end else begin
			new_entry.min_value = cells[0].min_value;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t above;
		entry_t below;

		if (i == 0) begin : g_head
			assign above = new_entry;
		end else begin : g_link
			assign above = cells[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign below = '0;
		end else begin : g_next
			assign below = cells[i+1];
		end

		mts_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.from_above (above),
			.from_below (below),
			.entry      (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Response describes the stack after this request's action.
	always_comb begin
		nxt_top   = EMPTY_READ;
		nxt_min   = EMPTY_READ;
		nxt_empty = 1'b1;
		if (ctrl.push) begin
			nxt_top   = new_entry.value;
			nxt_min   = new_entry.min_value;
			nxt_empty = 1'b0;
		end else if (ctrl.pop) begin
			if (count_q != CNT_W'(1)) begin
				nxt_top   = cells[1].value;
				nxt_min   = cells[1].min_value;
				nxt_empty = 1'b0;
			end
		end else if (!stack_empty) begin
			nxt_top   = cells[0].value;
			nxt_min   = cells[0].min_value;
			nxt_empty = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_top_q   <= nxt_top;
			rsp_min_q   <= nxt_min;
			rsp_empty_q <= nxt_empty;
			rsp_ovf_q   <= is_push && stack_full;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.top_value = rsp_top_q;
	assign rsp.min_value = rsp_min_q;
	assign rsp.is_empty  = rsp_empty_q;
	assign rsp.overflow  = rsp_ovf_q;

endmodule

### verif/tb.sv
// Testbench for min_tracking_stack_top: drives push, pop and query items and checks every response.
// Uses a shadow stack to predict each response, with random stalls on both channels.
// Depends on mts_pkg, mts_req_if, mts_rsp_if and the RTL of min_tracking_stack_top.
`timescale 1ns / 100ps

module tb;
	import mts_pkg::*;

	localparam int STACK_DEPTH = DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS = 850;
	localparam int QUIET_ITEMS = 100;
	localparam int unsigned CYCLE_LIMIT = 250000;
	localparam int DRAIN_CYCLES = 10;
	// Action code 3 is unused by the block and must behave as a query.
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

	typedef struct {
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] min_value;
		logic                     is_empty;
		logic                     overflow;
	} stack_view_t;

	class stack_scoreboard;
		entry_t        held[STACK_DEPTH];
		int unsigned   fill;
		stack_view_t   pending_views[$];
		int unsigned   errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		// Apply one accepted request to the shadow stack and queue the response it causes.
		function void note_request(logic [ACTION_W-1:0] action, logic signed [DATA_W-1:0] value);
			stack_view_t view;
			logic signed [DATA_W-1:0] running_min;
			view.overflow = 1'b0;
			if (action == ACT_PUSH) begin
				if (fill == STACK_DEPTH) begin
					view.overflow = 1'b1;
				end else begin
					running_min = value;
					if (fill > 0 && held[fill-1].min_value < value)
						running_min = held[fill-1].min_value;
					held[fill].value = value;
					held[fill].min_value = running_min;
					fill++;
				end
			end else if (action == ACT_POP) begin
				if (fill > 0)
					fill--;
			end
			if (fill == 0) begin
				view.top_value = EMPTY_READ;
				view.min_value = EMPTY_READ;
				view.is_empty = 1'b1;
			end else begin
				view.top_value = held[fill-1].value;
				view.min_value = held[fill-1].min_value;
				view.is_empty = 1'b0;
			end
			pending_views.push_back(view);
		endfunction

		function void check_response(logic signed [DATA_W-1:0] top_value,
				logic signed [DATA_W-1:0] min_value, logic is_empty, logic overflow);
			stack_view_t want;
			if (pending_views.size() == 0) begin
				$display("%0t: response with no request waiting (top %0d min %0d)",
					$time, top_value, min_value);
				errors++;
				return;
			end
			want = pending_views.pop_front();
			if (top_value !== want.top_value) begin
				$display("%0t: top_value expected %0d got %0d", $time, want.top_value, top_value);
				errors++;
			end
			if (min_value !== want.min_value) begin
				$display("%0t: min_value expected %0d got %0d", $time, want.min_value, min_value);
				errors++;
			end
			if (is_empty !== want.is_empty) begin
				$display("%0t: is_empty expected %0b got %0b", $time, want.is_empty, is_empty);
				errors++;
			end
			if (overflow !== want.overflow) begin
				$display("%0t: overflow expected %0b got %0b", $time, want.overflow, overflow);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_views.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit quiet = 1'b0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned quiet_start;
	stack_scoreboard sb = new();

	mts_req_if req_ch();
	mts_rsp_if rsp_ch();

	min_tracking_stack_top #(.DEPTH(STACK_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
			sb.check_response(rsp_ch.top_value, rsp_ch.min_value, rsp_ch.is_empty,
				rsp_ch.overflow);
	end

	// Response side: ready is dropped at random, never in the quiet tail.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $signed($urandom_range(0, 16)) - 8;
		if (r < 6) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7FFFFFFF;
				1: return 32'sh80000000;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom();
	endfunction

	// Valid is only lowered here, while draining or at the end, so it never falls and rises in one step.
	task automatic send_item(logic [ACTION_W-1:0] action, logic signed [DATA_W-1:0] value);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= action;
		req_ch.value <= value;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(action, value);
		items_sent++;
		if (items_sent >= quiet_start)
			quiet = 1'b1;
	endtask

	task automatic pause_until_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	task automatic run_directed();
		send_item(ACT_NONE, 32'sd0);
		send_item(ACT_POP, 32'sd9);
		send_item(ACT_SPARE, 32'sd9);
		send_item(ACT_PUSH, 32'sd5);
		send_item(ACT_PUSH, 32'sd7);
		send_item(ACT_PUSH, 32'sd5);
		send_item(ACT_PUSH, 32'sd3);
		send_item(ACT_POP, 32'sd0);
		send_item(ACT_POP, 32'sd0);
		send_item(ACT_PUSH, 32'sh7FFFFFFF);
		send_item(ACT_PUSH, 32'sh80000000);
		send_item(ACT_PUSH, 32'sd0);
		send_item(ACT_PUSH, -32'sd1);
		send_item(ACT_SPARE, 32'sh5A5A5A5A);
		send_item(ACT_NONE, -32'sd1);
		repeat (6) send_item(ACT_POP, 32'sd0);
		send_item(ACT_POP, 32'sd0);
		// A stored -1 must still read as a non-empty stack.
		send_item(ACT_PUSH, -32'sd1);
		send_item(ACT_POP, 32'sd0);
	endtask

	// Fill past capacity to force dropped pushes, then drain past empty.
	task automatic fill_and_drain();
		while (sb.fill < STACK_DEPTH) begin
			if ($urandom_range(0, 9) == 0)
				send_item(ACT_NONE, pick_value());
			else
				send_item(ACT_PUSH, pick_value());
		end
		repeat ($urandom_range(1, 4)) send_item(ACT_PUSH, pick_value());
		while (sb.fill > 0) begin
			if ($urandom_range(0, 9) == 0)
				send_item(ACT_SPARE, pick_value());
			else
				send_item(ACT_POP, pick_value());
		end
		repeat ($urandom_range(1, 3)) send_item(ACT_POP, pick_value());
	endtask

	task automatic random_walk();
		int unsigned seg_len;
		int unsigned push_pct;
		int unsigned r;
		seg_len = $urandom_range(20, 60);
		case ($urandom_range(0, 3))
			0: push_pct = 25;
			1: push_pct = 50;
			2: push_pct = 75;
			default: push_pct = 90;
		endcase
		repeat (seg_len) begin
			r = $urandom_range(0, 99);
			if (r < push_pct)
				send_item(ACT_PUSH, pick_value());
			else if (r % 8 == 0)
				send_item($urandom_range(0, 1) ? ACT_NONE : ACT_SPARE, pick_value());
			else
				send_item(ACT_POP, pick_value());
		end
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(5, 15))
			send_item(ACT_SPARE & 2'($urandom_range(0, 3)), pick_value());
	endtask

	task automatic run_random();
		int unsigned stop_at;
		int unsigned kind;
		stop_at = items_sent + RANDOM_ITEMS;
		fill_and_drain();
		pause_until_drained();
		while (items_sent < stop_at) begin
			kind = $urandom_range(0, 7);
			if (kind == 0)
				fill_and_drain();
			else if (kind == 1)
				noise_burst();
			else
				random_walk();
		end
	endtask

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_NONE;
		req_ch.value <= '0;
		quiet_start = 1000000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		pause_until_drained();
		quiet_start = items_sent + RANDOM_ITEMS - QUIET_ITEMS;
		run_random();
		req_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
